// ===== rtl/svf_three_band_eq_assert.svh =====
// assertion macros for the three-band equalizer
// no dependencies; simulation bodies are compiled out when SYNTH is defined
`ifndef SVF_THREE_BAND_EQ_ASSERT_SVH
`define SVF_THREE_BAND_EQ_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SVF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SVF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SVF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SVF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/svf3eq_pkg.sv =====
// shared types, widths and fixed-point helpers for the three-band equalizer
// no dependencies
package svf3eq_pkg;

  localparam int FREQ_W   = 17;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int CHAN_W   = 4;
  localparam int STATE_W  = 24;
  localparam int X_W      = 20;
  localparam int HP_W     = 26;
  localparam int SUM_W    = 26;
  localparam int SH_W     = 28;
  localparam int MUL_A_W  = 28;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = 46;
  localparam int RN_W     = PROD_W - 16;
  localparam int ACC_W    = 47;
  localparam int QF_W     = ACC_W + 1 - 19;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 17'd1702;

  localparam logic signed [RN_W:0] STATE_HI = 8388607;
  localparam logic signed [RN_W:0] STATE_LO = -8388608;

  localparam logic signed [PROD_W-1:0] RND_POS = 32768;
  localparam logic signed [PROD_W-1:0] RND_NEG = 32767;

  // half of 3 * 2^19, added before the divide
  localparam logic signed [ACC_W:0] OUT_HALF = 786432;
  // quotient after the shift at which the divide by three reaches the limit
  localparam logic [QF_W-1:0] Q_SAT = 49152;
  // ceil(2^17 / 3), exact for 17-bit dividends
  localparam logic signed [MUL_B_W-1:0] RECIP3 = 43691;

  localparam logic signed [SAMPLE_W-1:0] OUT_LIMIT = 16384;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic [GAIN_W-1:0]     hg;
    logic [GAIN_W-1:0]     mg;
    logic [GAIN_W-1:0]     lg;
  } lane_cmd_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] value;
  } lane_res_t;

  // product / 2^16, rounded to nearest with ties away from zero
  function automatic logic signed [RN_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + (p[PROD_W-1] ? RND_NEG : RND_POS);
    return s[PROD_W-1:16];
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [RN_W:0] v);
    logic signed [RN_W:0] r;
    r = v;
    if (v > STATE_HI) begin
      r = STATE_HI;
    end else if (v < STATE_LO) begin
      r = STATE_LO;
    end
    return r[STATE_W-1:0];
  endfunction

endpackage

// ===== rtl/svf3eq_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module svf3eq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/svf3eq_lane.sv =====
// one side of the equalizer: state variable filter with per-channel state ram
// depends on svf3eq_pkg and svf3eq_ram
module svf3eq_lane #(
  parameter int NUM_CHANNELS = 16,
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  go,
  input  svf3eq_pkg::lane_cmd_t                 cmd,
  input  logic [CH_W-1:0]                       addr,
  input  logic [svf3eq_pkg::FREQ_W-1:0]         freq_coeff,
  output svf3eq_pkg::lane_res_t                 res
);

  localparam int VLD_N = 1 << CH_W;
  localparam int SW    = svf3eq_pkg::STATE_W;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_READ   = 13'b0000000000010,
    S_MUL_B  = 13'b0000000000100,
    S_UPD_L  = 13'b0000000001000,
    S_MUL_H  = 13'b0000000010000,
    S_UPD_B  = 13'b0000000100000,
    S_GAIN_H = 13'b0000001000000,
    S_GAIN_M = 13'b0000010000000,
    S_GAIN_L = 13'b0000100000000,
    S_ACC    = 13'b0001000000000,
    S_ROUND  = 13'b0010000000000,
    S_DIV    = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } lane_state_t;

  lane_state_t state, state_next;
  logic [1:0]  step;

  logic signed [SW-1:0]                         low, band;
  logic signed [svf3eq_pkg::HP_W-1:0]           hp;
  logic signed [svf3eq_pkg::SUM_W-1:0]          sl, sb;
  logic signed [svf3eq_pkg::SH_W-1:0]           sh;
  logic signed [svf3eq_pkg::PROD_W-1:0]         prod;
  logic signed [svf3eq_pkg::ACC_W-1:0]          acc;
  logic [15:0]                                  q16;
  logic                                         neg, sat;

  logic signed [svf3eq_pkg::MUL_A_W-1:0]        mul_a;
  logic signed [svf3eq_pkg::MUL_B_W-1:0]        mul_b;
  logic signed [SW-1:0]                         low_next, band_next;
  logic signed [svf3eq_pkg::ACC_W:0]            acc_x, mag;
  logic [svf3eq_pkg::QF_W-1:0]                  q_full;
  logic signed [svf3eq_pkg::SAMPLE_W-1:0]       out_mag;

  logic [VLD_N-1:0]  vld;
  logic              vld_q;
  logic              ram_we;
  logic [2*SW-1:0]   ram_rd;

  svf3eq_ram #(.WIDTH(2 * SW), .DEPTH(NUM_CHANNELS)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata ({low, band_next}),
    .raddr (addr),
    .rdata (ram_rd)
  );

  assign ram_we = (state == S_UPD_B) && (step == 2'd2);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_B: begin
        mul_a = svf3eq_pkg::MUL_A_W'(band);
        mul_b = svf3eq_pkg::MUL_B_W'($signed({1'b0, freq_coeff}));
      end
      S_MUL_H: begin
        mul_a = svf3eq_pkg::MUL_A_W'(hp);
        mul_b = svf3eq_pkg::MUL_B_W'($signed({1'b0, freq_coeff}));
      end
      S_GAIN_H: begin
        mul_a = svf3eq_pkg::MUL_A_W'(sh);
        mul_b = svf3eq_pkg::MUL_B_W'($signed({1'b0, cmd.hg}));
      end
      S_GAIN_M: begin
        mul_a = svf3eq_pkg::MUL_A_W'(sb);
        mul_b = svf3eq_pkg::MUL_B_W'($signed({1'b0, cmd.mg}));
      end
      S_GAIN_L: begin
        mul_a = svf3eq_pkg::MUL_A_W'(sl);
        mul_b = svf3eq_pkg::MUL_B_W'($signed({1'b0, cmd.lg}));
      end
      S_DIV: begin
        mul_a = svf3eq_pkg::MUL_A_W'($signed({1'b0, q16}));
        mul_b = svf3eq_pkg::RECIP3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    low_next  = svf3eq_pkg::sat_state((svf3eq_pkg::RN_W + 1)'(low)
                + (svf3eq_pkg::RN_W + 1)'(svf3eq_pkg::round_q16(prod)));
    band_next = svf3eq_pkg::sat_state((svf3eq_pkg::RN_W + 1)'(band)
                + (svf3eq_pkg::RN_W + 1)'(svf3eq_pkg::round_q16(prod)));
    acc_x     = (svf3eq_pkg::ACC_W + 1)'(acc);
    // magnitude plus half the divisor, one add or subtract
    mag       = acc[svf3eq_pkg::ACC_W-1] ? (svf3eq_pkg::OUT_HALF - acc_x)
                                         : (acc_x + svf3eq_pkg::OUT_HALF);
    q_full    = mag[svf3eq_pkg::ACC_W:19];
    out_mag   = sat ? svf3eq_pkg::OUT_LIMIT : $signed({1'b0, prod[31:17]});
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (go) state_next = S_READ;
      S_READ:   state_next = S_MUL_B;
      S_MUL_B:  state_next = S_UPD_L;
      S_UPD_L:  state_next = S_MUL_H;
      S_MUL_H:  state_next = S_UPD_B;
      S_UPD_B:  state_next = (step == 2'd2) ? S_GAIN_H : S_MUL_B;
      S_GAIN_H: state_next = S_GAIN_M;
      S_GAIN_M: state_next = S_GAIN_L;
      S_GAIN_L: state_next = S_ACC;
      S_ACC:    state_next = S_ROUND;
      S_ROUND:  state_next = S_DIV;
      S_DIV:    state_next = S_FIN;
      S_FIN:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      vld      <= '0;
      res.done <= 1'b0;
      step     <= 2'd0;
    end else begin
      state    <= state_next;
      res.done <= (state == S_FIN);
      if (state == S_FIN) begin
        res.value <= neg ? -out_mag : out_mag;
      end
      if (ram_we) begin
        vld[addr] <= 1'b1;
      end
      if (state == S_READ) begin
        step <= 2'd0;
      end else if (state == S_UPD_B) begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    vld_q <= vld[addr];
    case (state)
      S_READ: begin
        // a channel never written reads as zero state
        low  <= vld_q ? $signed(ram_rd[2*SW-1:SW]) : '0;
        band <= vld_q ? $signed(ram_rd[SW-1:0]) : '0;
        sl   <= '0;
        sb   <= '0;
        sh   <= '0;
      end
      S_UPD_L: begin
        low <= low_next;
        hp  <= svf3eq_pkg::HP_W'(cmd.x) - svf3eq_pkg::HP_W'(low_next)
               - svf3eq_pkg::HP_W'(band);
        sl  <= sl + svf3eq_pkg::SUM_W'(low_next);
      end
      S_UPD_B: begin
        band <= band_next;
        sb   <= sb + svf3eq_pkg::SUM_W'(band_next);
        sh   <= sh + svf3eq_pkg::SH_W'(hp);
      end
      S_GAIN_M: acc <= svf3eq_pkg::ACC_W'(prod);
      S_GAIN_L: acc <= acc + svf3eq_pkg::ACC_W'(prod);
      S_ACC:    acc <= acc + svf3eq_pkg::ACC_W'(prod);
      S_ROUND: begin
        neg <= acc[svf3eq_pkg::ACC_W-1];
        sat <= (q_full >= svf3eq_pkg::Q_SAT);
        q16 <= q_full[15:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/svf_three_band_eq.sv =====
// Stereo three-band equalizer on a state variable filter, per-channel state.
// Input stream: tuser = channel, tdata = left, right, high, mid and low gain.
// Output stream: tdata = left_out, right_out (Q1.14, limited to +/-16384).
// Config: cfg_we writes freq_coeff (Q1.16) from cfg_wdata; write only while idle.
// Two lanes, left and right, run side by side with one multiplier each and
// per-channel state memories; the output register merges both results.
// For a valid channel the result comes from the lane sequence of three
// filter sub-steps of two dependent multiplies each, plus gain, rounding and
// divide steps, and then passes through the output register.
// A channel at or beyond NUM_CHANNELS skips the lanes and gives a zero result.
// Items are taken one at a time; s_axis_tready is high whenever no item
// is in the lanes, also while a result still waits in the output register.
// When the receiver stalls, a finished result stays in the lanes until the
// output register frees up, and no new item is taken until then.
// Reset: filter state of all channels reads as zero, freq_coeff returns to
// 1702, both streams empty; no clearing pass is needed.
// depends on svf3eq_pkg, svf3eq_lane, svf3eq_ram and the assertion header
`include "svf_three_band_eq_assert.svh"

module svf_three_band_eq #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_in[15:0], right_in[31:16], high_gain[47:32], mid_gain[63:48], low_gain[79:64]
  input  logic [79:0] s_axis_tdata,
  // channel[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_out[15:0], right_out[31:16]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [svf3eq_pkg::FREQ_W-1:0] freq_coeff;
  logic                          busy, go, zero_res;
  logic [1:0]                    done_seen;
  logic [CH_W-1:0]               ch_addr;
  svf3eq_pkg::lane_cmd_t         cmd [2];
  svf3eq_pkg::lane_res_t         lane_res [2];

  logic in_acc, in_ok, merge;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_ok         = {28'd0, s_axis_tuser} < 32'(NUM_CHANNELS);
  assign s_axis_tready = !busy;
  assign merge         = busy && (&done_seen) && (!m_axis_tvalid || m_axis_tready);

  for (genvar i = 0; i < 2; i++) begin : g_lane
    svf3eq_lane #(.NUM_CHANNELS(NUM_CHANNELS)) u_lane (
      .clk        (clk),
      .rst        (rst),
      .go         (go),
      .cmd        (cmd[i]),
      .addr       (ch_addr),
      .freq_coeff (freq_coeff),
      .res        (lane_res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_coeff    <= svf3eq_pkg::FREQ_RESET;
      busy          <= 1'b0;
      go            <= 1'b0;
      zero_res      <= 1'b0;
      done_seen     <= 2'b00;
      m_axis_tvalid <= 1'b0;
    end else begin
      go <= 1'b0;
      if (cfg_we) begin
        freq_coeff <= cfg_wdata;
      end
      if (in_acc) begin
        busy      <= 1'b1;
        go        <= in_ok;
        zero_res  <= !in_ok;
        // a channel out of range skips the lanes
        done_seen <= in_ok ? 2'b00 : 2'b11;
      end else begin
        for (int i = 0; i < 2; i++) begin
          if (lane_res[i].done) begin
            done_seen[i] <= 1'b1;
          end
        end
      end
      if (merge) begin
        busy          <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_addr   <= CH_W'(s_axis_tuser);
      cmd[0].x  <= $signed({s_axis_tdata[15:0], 4'b0000});
      cmd[1].x  <= $signed({s_axis_tdata[31:16], 4'b0000});
      cmd[0].hg <= s_axis_tdata[47:32];
      cmd[1].hg <= s_axis_tdata[47:32];
      cmd[0].mg <= s_axis_tdata[63:48];
      cmd[1].mg <= s_axis_tdata[63:48];
      cmd[0].lg <= s_axis_tdata[79:64];
      cmd[1].lg <= s_axis_tdata[79:64];
    end
    if (merge) begin
      m_axis_tdata <= zero_res ? 32'd0 : {lane_res[1].value, lane_res[0].value};
    end
  end

  `SVF_ASSERT_IMP(a_lanes_lockstep, clk, rst, lane_res[0].done || lane_res[1].done, lane_res[0].done && lane_res[1].done, "lanes finished in different cycles")
  `SVF_ASSERT_IMP(a_done_only_busy, clk, rst, lane_res[0].done, busy && !zero_res, "lane finished with no item in flight")
  `SVF_ASSERT_NXT(a_bad_channel, clk, rst, in_acc && !in_ok, zero_res && !go && busy, "out of range channel started the lanes")
  `SVF_ASSERT_IMP(a_out_limit, clk, rst, m_axis_tvalid, $signed(m_axis_tdata[15:0]) <= svf3eq_pkg::OUT_LIMIT && $signed(m_axis_tdata[15:0]) >= -svf3eq_pkg::OUT_LIMIT && $signed(m_axis_tdata[31:16]) <= svf3eq_pkg::OUT_LIMIT && $signed(m_axis_tdata[31:16]) >= -svf3eq_pkg::OUT_LIMIT, "output beyond limit")

endmodule
